### hw/rtl/bfba_pkg.sv
// Shared types and constants for the best-fit block allocator.
`default_nettype none

package bfba_pkg;

  localparam int DEF_MAX_BLOCKS   = 16;
  localparam int DEF_HEADER_BYTES = 8;

  localparam int ADDR_W = 3;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  localparam logic [31:0] RST_HEAP_BASE = 32'd0;
  localparam logic [31:0] RST_HEAP_SIZE = 32'd65536;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOTALLOC = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] req_size;
    logic [31:0] free_addr;
  } req_item_t;

  typedef struct packed {
    logic [31:0] addr_out;
    logic [1:0]  status;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
  } desc_t;

endpackage

`default_nettype wire

### hw/rtl/best_fit_block_allocator.sv
// Best-fit heap allocator over a table of block descriptors.
// Allocate scans the table, decides, and with a split writes the spare entry, then shrinks the best fit;
//   free scans and decides; a zero-size allocate goes straight to the result.
// A new request is not taken until the previous result is loaded; the descriptor scan reads one entry
//   per cycle from the single read port of the descriptor memory.
// Reset is synchronous: registers return to heap_base 0, heap_size 65536 and the table to
//   one free block spanning the heap; a register write re-initializes the table the same way.
`default_nettype none

module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_item_t         req_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_item_t              rsp_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = IW + 1;
  localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);
  localparam logic [CW-1:0] NBLK = CW'(MAX_BLOCKS);
  localparam logic [31:0]   HDR  = 32'(HEADER_BYTES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SPLIT  = 6'b001000,
    S_SHRINK = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;

  logic [31:0] heap_base;
  logic [31:0] heap_size;
  logic [MAX_BLOCKS-1:0] valid;
  logic [MAX_BLOCKS-1:0] used;
  logic        fresh0;

  logic        cmd;
  logic [32:0] need;
  logic [31:0] faddr;
  logic [CW-1:0] cnt;
  logic        rd_vld;
  logic [IW-1:0] rd_idx;

  logic        best_found;
  logic [IW-1:0] best_idx;
  logic [31:0] best_base;
  logic [31:0] best_len;
  logic        spare_found;
  logic [IW-1:0] spare_idx;
  logic        match_found;
  logic [IW-1:0] match_idx;

  logic [31:0] res_addr;
  logic [1:0]  res_status;

  logic        acc;
  logic        cfg_wr;
  logic        issue;
  logic        rsp_load;
  logic        split_ok;
  logic [31:0] need32;
  desc_t       rd_data;
  desc_t       cur;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  desc_t       mem_wdata;

  assign pready    = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign acc       = req_valid && !req_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign issue     = (state == S_SCAN) && (cnt < NBLK);
  assign rsp_load  = (state == S_RESULT) && (!rsp_valid || !rsp_stall);
  assign need32    = need[31:0];
  assign split_ok  = (best_len > need32) && spare_found;

  always_comb begin
    case (paddr[2])
      REG_HEAP_BASE: prdata = heap_base;
      REG_HEAP_SIZE: prdata = heap_size;
      default:       prdata = '0;
    endcase
  end

  // Entry zero reads from the registers until the sequencer first rewrites it.
  always_comb begin
    if (rd_idx == '0 && fresh0) begin
      cur.base = heap_base;
      cur.len  = heap_size;
    end else begin
      cur = rd_data;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata.base = best_base;
    mem_wdata.len  = need32;
    if (state == S_SPLIT) begin
      mem_we    = 1'b1;
      mem_waddr = spare_idx;
      mem_wdata.base = best_base + need32;
      mem_wdata.len  = best_len - need32;
    end else if (state == S_SHRINK) begin
      mem_we    = 1'b1;
    end
  end

  bfba_desc_mem #(
    .DEPTH (MAX_BLOCKS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (rd_data)
  );

  // Control: sequencer, table flags, registers, output beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      heap_base <= RST_HEAP_BASE;
      heap_size <= RST_HEAP_SIZE;
      valid     <= MAX_BLOCKS'(1);
      used      <= '0;
      fresh0    <= 1'b1;
    end else begin
      rd_vld <= issue;
      if (cfg_wr) begin
        if (paddr[2] == REG_HEAP_BASE) begin
          heap_base <= pwdata;
        end else begin
          heap_size <= pwdata;
        end
        valid    <= MAX_BLOCKS'(1);
        used     <= '0;
        fresh0   <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (req_data.command == CMD_ALLOC && req_data.req_size == '0) begin
              state <= S_RESULT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld && rd_idx == LAST) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd == CMD_ALLOC) begin
            if (!best_found) begin
              state <= S_RESULT;
            end else if (split_ok) begin
              state <= S_SPLIT;
            end else begin
              used[best_idx] <= 1'b1;
              state <= S_RESULT;
            end
          end else begin
            if (match_found) begin
              used[match_idx] <= 1'b0;
            end
            state <= S_RESULT;
          end
        end
        S_SPLIT: begin
          valid[spare_idx] <= 1'b1;
          used[spare_idx]  <= 1'b0;
          if (spare_idx == '0) begin
            fresh0 <= 1'b0;
          end
          state <= S_SHRINK;
        end
        S_SHRINK: begin
          used[best_idx] <= 1'b1;
          if (best_idx == '0) begin
            fresh0 <= 1'b0;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath: request latch, scan bookkeeping, result.
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd         <= req_data.command;
      need        <= {1'b0, req_data.req_size} + {1'b0, HDR};
      faddr       <= req_data.free_addr;
      cnt         <= '0;
      best_found  <= 1'b0;
      spare_found <= 1'b0;
      match_found <= 1'b0;
      res_addr    <= '0;
      res_status  <= ST_ZERO;
    end
    if (issue) begin
      cnt    <= cnt + CW'(1);
      rd_idx <= cnt[IW-1:0];
    end
    if (state == S_SCAN && rd_vld) begin
      if (!valid[rd_idx]) begin
        if (!spare_found) begin
          spare_found <= 1'b1;
          spare_idx   <= rd_idx;
        end
      end else if (cmd == CMD_ALLOC) begin
        if (!used[rd_idx] && {1'b0, cur.len} >= need &&
            (!best_found || cur.len < best_len)) begin
          best_found <= 1'b1;
          best_idx   <= rd_idx;
          best_base  <= cur.base;
          best_len   <= cur.len;
        end
      end else begin
        if (used[rd_idx] && !match_found && (cur.base + HDR) == faddr) begin
          match_found <= 1'b1;
          match_idx   <= rd_idx;
        end
      end
    end
    if (state == S_DECIDE) begin
      if (cmd == CMD_ALLOC) begin
        if (best_found) begin
          res_status <= ST_OK;
          res_addr   <= best_base + HDR;
        end else begin
          res_status <= ST_NOFIT;
          res_addr   <= '0;
        end
      end else begin
        res_status <= match_found ? ST_OK : ST_NOTALLOC;
        res_addr   <= '0;
      end
    end
    if (rsp_load) begin
      rsp_data.addr_out <= res_addr;
      rsp_data.status   <= res_status;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bfba_desc_mem.sv
// Block descriptor memory: one write port, one registered read port.
`default_nettype none

module bfba_desc_mem
  import bfba_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_BLOCKS,
  parameter int IW    = $clog2(DEF_MAX_BLOCKS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire desc_t         wdata,
  input  wire logic [IW-1:0] raddr,
  output desc_t              rdata
);

  desc_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/bfba_checker.sv
// Port-level checks for the best-fit block allocator, bound to the top level.
`default_nettype none

module bfba_checker
  import bfba_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      req_valid,
  input wire logic      req_stall,
  input wire logic      rsp_valid,
  input wire logic      rsp_stall,
  input wire rsp_item_t rsp_data,
  input wire logic      pready
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response beat right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a request is in progress");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.addr_out == '0))
    else $error("nonzero address with a failing status");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled response beat changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port not ready");

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data),
  .pready    (pready)
);

`default_nettype wire
